/* hdl/ttpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpu_pkg
// shared types and constants of the tile pixel unpacker
// ----------------------------------------------------------------------------
package ttpu_pkg;

	localparam int unsigned INDEX_BITS = 28;

	localparam logic [1:0] FMT_U16 = 2'd0;
	localparam logic [1:0] FMT_U32 = 2'd1;
	localparam logic [1:0] FMT_F32 = 2'd2;

	localparam logic [2:0] REG_FORMAT  = 3'd0;
	localparam logic [2:0] REG_PRED    = 3'd1;
	localparam logic [2:0] REG_ENDIAN  = 3'd2;
	localparam logic [2:0] REG_IMG_W   = 3'd3;
	localparam logic [2:0] REG_IMG_H   = 3'd4;
	localparam logic [2:0] REG_TILE_W  = 3'd5;
	localparam logic [2:0] REG_TILE_H  = 3'd6;

	typedef struct packed {
		logic        valid;
		logic        in_img;
		logic        done;
		logic [1:0]  fmt;
		logic [31:0] val;
		logic [15:0] grow;
		logic [15:0] gcol;
	} stage1_t;

endpackage

/* hdl/ttpu_u32_to_f32.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpu_u32_to_f32
// unsigned 32-bit integer to ieee single, round to nearest even
// ----------------------------------------------------------------------------
module ttpu_u32_to_f32 (
	input  logic [31:0] value,
	output logic [31:0] bits
);
	logic [4:0]  p;
	logic [31:0] norm;
	logic [23:0] mant;
	logic        guard, sticky;
	logic [24:0] rnd;
	logic [7:0]  expo;

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (value[i]) p = 5'(i);
		end
		norm = value << (5'd31 - p);
		mant = norm[31:8];
		guard = norm[7];
		sticky = |norm[6:0];
		rnd = {1'b0, mant} + 25'(guard && (sticky || mant[0]));
		expo = 8'(p) + 8'd127 + 8'(rnd[24]);
		if (value == 32'd0) bits = 32'd0;
		else if (rnd[24]) bits = {1'b0, expo, 23'd0};
		else bits = {1'b0, expo, rnd[22:0]};
	end
endmodule

/* hdl/tiff_tile_pixel_unpacker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiff_tile_pixel_unpacker_core
// tiff tile sample unpacker with horizontal predictor undo
// ----------------------------------------------------------------------------
// One sample beat enters per cycle unless stalled and, if it lands inside the
// raster, leaves as one pixel beat via the stage one and output registers. Stage
// one does byte order, predictor add and raster bounds; stage two does the index
// multiply and the float conversion into the output register. The predictor
// accumulator and tile position update in the accept cycle, so back-to-back beats
// chain without bubbles. Padding beats advance position but give no output beat.
module tiff_tile_pixel_unpacker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tile_start,
	input  logic [15:0] tile_row,
	input  logic [15:0] tile_col,
	input  logic [31:0] sample_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [27:0] pixel_index,
	output logic [31:0] pixel_bits,
	output logic        tile_done
);
	logic [1:0]  fmt_q;
	logic        pred_q, be_q;
	logic [15:0] img_w_q, img_h_q, tile_w_q, tile_h_q;
	logic [15:0] row_q, col_q;
	logic [31:0] sum_q;
	ttpu_pkg::stage1_t s1_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= ttpu_pkg::FMT_U16; pred_q <= 1'b0; be_q <= 1'b0;
			img_w_q <= 16'd1; img_h_q <= 16'd1; tile_w_q <= 16'd1; tile_h_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttpu_pkg::REG_FORMAT: fmt_q <= cfg_data[1:0];
				ttpu_pkg::REG_PRED:   pred_q <= cfg_data[0];
				ttpu_pkg::REG_ENDIAN: be_q <= cfg_data[0];
				ttpu_pkg::REG_IMG_W:  img_w_q <= cfg_data;
				ttpu_pkg::REG_IMG_H:  img_h_q <= cfg_data;
				ttpu_pkg::REG_TILE_W: tile_w_q <= cfg_data;
				ttpu_pkg::REG_TILE_H: tile_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage two is the output register; pipeline moves unless it holds a stalled beat
	logic advance;
	assign advance = !(out_valid && out_stall);
	logic s1_move;
	assign s1_move = advance || !s1_q.valid;
	assign in_stall = !s1_move;
	logic acc;
	assign acc = in_valid && s1_move;

	logic [15:0] tw, th, row_c, col_c;
	logic        is16;
	logic [31:0] v, sum_c, val;
	logic [31:0] grow32, gcol32, endr32, endc32;
	logic [32:0] endr_c, endc_c;
	logic        in_img, done;

	always_comb begin
		tw = (tile_w_q == 16'd0) ? 16'd1 : tile_w_q;
		th = (tile_h_q == 16'd0) ? 16'd1 : tile_h_q;
		row_c = tile_start ? 16'd0 : row_q;
		col_c = tile_start ? 16'd0 : col_q;
		sum_c = (col_c == 16'd0) ? 32'd0 : sum_q;
		is16 = (fmt_q == ttpu_pkg::FMT_U16);
		if (is16) v = be_q ? {16'd0, sample_word[7:0], sample_word[15:8]}
		                   : {16'd0, sample_word[15:0]};
		else if (be_q) v = {sample_word[7:0], sample_word[15:8],
		                    sample_word[23:16], sample_word[31:24]};
		else v = sample_word;
		if (pred_q) begin
			val = sum_c + v;
			if (is16) val[31:16] = 16'd0;
		end else val = v;
		// 16x16 position products and 17x16 tile end products, two per path
		grow32 = 32'(tile_row) * 32'(th) + 32'(row_c);
		gcol32 = 32'(tile_col) * 32'(tw) + 32'(col_c);
		endr_c = (33'(tile_row) + 33'd1) * 33'(th);
		endc_c = (33'(tile_col) + 33'd1) * 33'(tw);
		endr32 = (endr_c > 33'(img_h_q)) ? 32'(img_h_q) : endr_c[31:0];
		endc32 = (endc_c > 33'(img_w_q)) ? 32'(img_w_q) : endc_c[31:0];
		in_img = (grow32 < 32'(img_h_q)) && (gcol32 < 32'(img_w_q));
		done = (grow32 == endr32 - 32'd1) && (gcol32 == endc32 - 32'd1);
	end

	// position and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 16'd0; col_q <= 16'd0; sum_q <= 32'd0;
		end else if (acc) begin
			sum_q <= val;
			if (17'(col_c) + 17'd1 >= 17'(tw)) begin
				col_q <= 16'd0;
				row_q <= (17'(row_c) + 17'd1 >= 17'(th)) ? 16'd0 : row_c + 16'd1;
			end else begin
				col_q <= col_c + 16'd1;
				row_q <= row_c;
			end
		end
	end

	// stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_q <= '0;
		else begin
			if (s1_move) s1_q.valid <= acc && in_img;
			if (acc) begin
				s1_q.in_img <= in_img; s1_q.done <= done; s1_q.fmt <= fmt_q;
				s1_q.val <= val; s1_q.grow <= grow32[15:0]; s1_q.gcol <= gcol32[15:0];
			end
		end
	end

	logic [31:0] fbits;
	ttpu_u32_to_f32 u_conv (.value(s1_q.val), .bits(fbits));
	logic [31:0] idx;
	assign idx = 32'(s1_q.grow) * 32'(img_w_q) + 32'(s1_q.gcol);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (advance) out_valid <= s1_q.valid;
	end
	always_ff @(posedge clk) begin
		if (advance && s1_q.valid) begin
			pixel_index <= idx[ttpu_pkg::INDEX_BITS-1:0];
			pixel_bits <= (s1_q.fmt == ttpu_pkg::FMT_F32) ? s1_q.val : fbits;
			tile_done <= s1_q.done && s1_q.in_img;
		end
	end
endmodule

/* hdl/ttpu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpu_checker
// port level checks of the tile pixel unpacker
// ----------------------------------------------------------------------------
module ttpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] pixel_bits
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_bits))
		else $error("stalled pixel beat changed");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output drains");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled sample beat withdrawn");
endmodule

bind tiff_tile_pixel_unpacker_core ttpu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pixel_bits(pixel_bits));
